@@ rtl/core/stq_pkg.sv @@
// Shared types, codes and helpers for the sorted timeout event queue.
package stq_pkg;

  // Command kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_INS_REL = 3'd1;
  localparam logic [2:0] KIND_INS_ABS = 3'd2;
  localparam logic [2:0] KIND_ADVANCE = 3'd3;
  localparam logic [2:0] KIND_QUERY   = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_FOREVER = 2'd2;

  // Most expiries one tick may report, and the counter width for it
  localparam int unsigned MAX_RES   = 16;
  localparam int unsigned RES_CNT_W = 5;

  // Fixed field widths
  localparam int unsigned ABS_W    = 48;
  localparam int unsigned PERIOD_W = 16;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       event_id;
    logic [31:0]      timeout;
    logic             wait_forever;
    logic [ABS_W-1:0] abs_time;
    logic [31:0]      elapsed;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        expired_valid;
    logic [7:0]  expired_id;
    logic        next_valid;
    logic [31:0] next_delay;
    logic        last;
  } res_word_t;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Build one result word
  function automatic res_word_t mk_res(logic [1:0] status, logic ev, logic [7:0] id,
                                       logic nv, logic [31:0] nd, logic lst);
    res_word_t r;
    r.status        = status;
    r.expired_valid = ev;
    r.expired_id    = id;
    r.next_valid    = nv;
    r.next_delay    = nd;
    r.last          = lst;
    return r;
  endfunction

endpackage

@@ rtl/core/sorted_timeout_event_queue_top.sv @@
// Top level of the sorted timeout event queue: sequencer, time and queue pointers.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one command word; cmd_stall
//   is high while a command is in progress, so one command is worked at a time.
//   res channel (res_valid / res_stall / res) returns result words from an
//   output register; the last word of each command has last set.
//   cfg_wr_en / cfg_wr_data write tick_period; write it only while idle.
// Commands run through one shared adder and one single-port entry store.
// Advance, wait forever and unknown kinds go straight to their one result word;
// query reads the head and subtracts the time, then the period (an empty queue
// skips both). Insert finishes the key, then scans back from the tail, moving
// each later entry one slot back; a full queue answers without a scan.
// Tick emits each due head entry one behind, until the head is not due, the
// queue empties or 16 are taken; it sends at most 16 words.
// The next command word is taken the cycle after the last result word loads.
// A stalled result word holds; the sequencer waits until the output register
// frees before loading the next word.
// Reset (synchronous, active high) empties the queue, zeroes the time and
// sets tick_period to 1. The store needs no clearing pass.
module sorted_timeout_event_queue_top #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  stq_pkg::cmd_word_t        cmd,
  output logic                      res_valid,
  input  logic                      res_stall,
  output stq_pkg::res_word_t        res,
  input  logic                      cfg_wr_en,
  input  logic [stq_pkg::PERIOD_W-1:0] cfg_wr_data
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned TW    = TIME_BITS;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_TICK_RD  = 10'b0000000010,
    S_TICK_CMP = 10'b0000000100,
    S_INS_ADD  = 10'b0000001000,
    S_INS_RD   = 10'b0000010000,
    S_INS_CMP  = 10'b0000100000,
    S_QRY_RD   = 10'b0001000000,
    S_QRY_SUB  = 10'b0010000000,
    S_QRY_FIN  = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_t;

  state_t                        state;
  logic [stq_pkg::PERIOD_W-1:0]  tick_period;
  logic [TW-1:0]                 cur_time;
  logic [TW-1:0]                 key;
  logic [TW-1:0]                 key_add;
  logic [7:0]                    ins_id;
  logic [CNT_W-1:0]              idx;
  logic [CNT_W-1:0]              count;
  logic [AW-1:0]                 head;
  logic [stq_pkg::RES_CNT_W-1:0] n_taken;
  logic                          have_pend;
  logic [7:0]                    pend_id;
  stq_pkg::res_word_t            res_pend;
  logic                          ret_idle;

  logic                          cmd_accept;
  logic                          out_free;
  logic [TW-1:0]                 period_ext;
  logic [TW-1:0]                 abs_ext;

  stq_pkg::alu_op_t              alu_op;
  logic [TW-1:0]                 alu_a;
  logic [TW-1:0]                 alu_b;
  logic [TW-1:0]                 alu_sum;
  logic                          alu_carry;

  logic [AW-1:0]                 lg_addr;
  logic [AW:0]                   phys_sum;
  logic [AW-1:0]                 mem_addr;
  logic                          mem_we;
  logic                          mem_re;
  logic [TW-1:0]                 mem_wr_time;
  logic [7:0]                    mem_wr_id;
  logic [TW-1:0]                 rd_time;
  logic [7:0]                    rd_id;
  logic [CNT_W-1:0]              idx_dec;
  logic                          tick_more;
  stq_pkg::res_word_t            tick_close;

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign out_free   = !res_valid || !res_stall;
  assign period_ext = TW'(tick_period);
  assign abs_ext    = TW'(cmd.abs_time);
  assign idx_dec    = idx - CNT_W'(1);

  // Tick may take another entry while the queue holds one and the budget lasts
  assign tick_more  = (count != '0) && (n_taken != stq_pkg::RES_CNT_W'(stq_pkg::MAX_RES));

  // Closing word of a tick: held expiry marked last, or the empty answer
  assign tick_close = have_pend ?
      stq_pkg::mk_res(stq_pkg::STATUS_OK, 1'b1, pend_id, 1'b0, 32'd0, 1'b1) :
      stq_pkg::mk_res(stq_pkg::STATUS_OK, 1'b0, 8'd0, 1'b0, 32'd0, 1'b1);

  // Operand select for the shared adder
  always_comb begin
    alu_op = stq_pkg::ALU_ADD;
    alu_a  = cur_time;
    alu_b  = period_ext;
    case (state)
      S_IDLE: begin
        alu_a = cur_time;
        case (cmd.kind)
          stq_pkg::KIND_INS_REL: alu_b = TW'(cmd.timeout);
          stq_pkg::KIND_ADVANCE: alu_b = TW'(cmd.elapsed);
          default:               alu_b = period_ext;
        endcase
      end
      S_INS_ADD: begin
        alu_a = key;
        alu_b = key_add;
      end
      S_INS_CMP: begin
        alu_op = stq_pkg::ALU_SUB;
        alu_a  = key;
        alu_b  = rd_time;
      end
      S_TICK_CMP: begin
        alu_op = stq_pkg::ALU_SUB;
        alu_a  = cur_time;
        alu_b  = rd_time;
      end
      S_QRY_SUB: begin
        alu_op = stq_pkg::ALU_SUB;
        alu_a  = rd_time;
        alu_b  = cur_time;
      end
      S_QRY_FIN: begin
        alu_op = stq_pkg::ALU_SUB;
        alu_a  = key;
        alu_b  = period_ext;
      end
      default: begin
        alu_op = stq_pkg::ALU_ADD;
      end
    endcase
  end

  stq_alu #(.TW(TW)) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // Store access: logical slot relative to head, then wrap to a physical slot
  always_comb begin
    lg_addr     = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wr_time = key;
    mem_wr_id   = ins_id;
    case (state)
      S_TICK_RD: begin
        mem_re = tick_more;
      end
      S_QRY_RD: begin
        mem_re = (count != '0);
      end
      S_INS_RD: begin
        if (idx == '0) begin
          mem_we = 1'b1;
        end else begin
          lg_addr = idx_dec[AW-1:0];
          mem_re  = 1'b1;
        end
      end
      S_INS_CMP: begin
        lg_addr = idx[AW-1:0];
        mem_we  = 1'b1;
        // entry later than the new key moves one slot back
        if (!alu_carry) begin
          mem_wr_time = rd_time;
          mem_wr_id   = rd_id;
        end
      end
      default: begin
        lg_addr = '0;
      end
    endcase
  end

  assign phys_sum = {1'b0, head} + {1'b0, lg_addr};
  assign mem_addr = (phys_sum >= (AW + 1)'(DEPTH)) ?
                    AW'(phys_sum - (AW + 1)'(DEPTH)) : phys_sum[AW-1:0];

  stq_mem #(.DEPTH(DEPTH), .TW(TW), .AW(AW)) u_mem (
    .clk     (clk),
    .addr    (mem_addr),
    .we      (mem_we),
    .wr_time (mem_wr_time),
    .wr_id   (mem_wr_id),
    .re      (mem_re),
    .rd_time (rd_time),
    .rd_id   (rd_id)
  );

  // Tick period register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= stq_pkg::PERIOD_W'(1);
    end else if (cfg_wr_en) begin
      tick_period <= cfg_wr_data;
    end
  end

  // Result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      res <= res_pend;
    end
  end

  // Sequencer and queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_time  <= '0;
      count     <= '0;
      head      <= '0;
      n_taken   <= '0;
      have_pend <= 1'b0;
      ret_idle  <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            ret_idle <= 1'b1;
            case (cmd.kind)
              stq_pkg::KIND_TICK: begin
                cur_time  <= alu_sum;
                n_taken   <= '0;
                have_pend <= 1'b0;
                state     <= S_TICK_RD;
              end
              stq_pkg::KIND_INS_REL: begin
                if (cmd.wait_forever) begin
                  res_pend <= stq_pkg::mk_res(stq_pkg::STATUS_FOREVER, 1'b0, 8'd0,
                                              1'b0, 32'd0, 1'b1);
                  state    <= S_EMIT;
                end else begin
                  key     <= alu_sum;
                  key_add <= period_ext;
                  ins_id  <= cmd.event_id;
                  state   <= S_INS_ADD;
                end
              end
              stq_pkg::KIND_INS_ABS: begin
                key     <= abs_ext;
                key_add <= '0;
                ins_id  <= cmd.event_id;
                state   <= S_INS_ADD;
              end
              stq_pkg::KIND_ADVANCE: begin
                cur_time <= alu_sum;
                res_pend <= stq_pkg::mk_res(stq_pkg::STATUS_OK, 1'b0, 8'd0,
                                            1'b0, 32'd0, 1'b1);
                state    <= S_EMIT;
              end
              stq_pkg::KIND_QUERY: begin
                state <= S_QRY_RD;
              end
              default: begin
                res_pend <= stq_pkg::mk_res(stq_pkg::STATUS_OK, 1'b0, 8'd0,
                                            1'b0, 32'd0, 1'b1);
                state    <= S_EMIT;
              end
            endcase
          end
        end

        // Tick: read head, compare against new time, emit one behind
        S_TICK_RD: begin
          if (tick_more) begin
            state <= S_TICK_CMP;
          end else begin
            res_pend <= tick_close;
            ret_idle <= 1'b1;
            state    <= S_EMIT;
          end
        end
        S_TICK_CMP: begin
          if (alu_carry) begin
            head      <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
            count     <= count - CNT_W'(1);
            n_taken   <= n_taken + stq_pkg::RES_CNT_W'(1);
            pend_id   <= rd_id;
            have_pend <= 1'b1;
            if (have_pend) begin
              res_pend <= stq_pkg::mk_res(stq_pkg::STATUS_OK, 1'b1, pend_id,
                                          1'b0, 32'd0, 1'b0);
              ret_idle <= 1'b0;
              state    <= S_EMIT;
            end else begin
              state <= S_TICK_RD;
            end
          end else begin
            res_pend <= tick_close;
            ret_idle <= 1'b1;
            state    <= S_EMIT;
          end
        end

        // Insert: finish the key, then scan back from the tail
        S_INS_ADD: begin
          key <= alu_sum;
          if (count == CNT_W'(DEPTH)) begin
            res_pend <= stq_pkg::mk_res(stq_pkg::STATUS_FULL, 1'b0, 8'd0,
                                        1'b0, 32'd0, 1'b1);
            state    <= S_EMIT;
          end else begin
            idx   <= count;
            state <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          if (idx == '0) begin
            count    <= count + CNT_W'(1);
            res_pend <= stq_pkg::mk_res(stq_pkg::STATUS_OK, 1'b0, 8'd0,
                                        1'b0, 32'd0, 1'b1);
            state    <= S_EMIT;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (!alu_carry) begin
            idx   <= idx_dec;
            state <= S_INS_RD;
          end else begin
            count    <= count + CNT_W'(1);
            res_pend <= stq_pkg::mk_res(stq_pkg::STATUS_OK, 1'b0, 8'd0,
                                        1'b0, 32'd0, 1'b1);
            state    <= S_EMIT;
          end
        end

        // Query: head time minus time minus period
        S_QRY_RD: begin
          if (count == '0) begin
            res_pend <= stq_pkg::mk_res(stq_pkg::STATUS_OK, 1'b0, 8'd0,
                                        1'b0, 32'd0, 1'b1);
            state    <= S_EMIT;
          end else begin
            state <= S_QRY_SUB;
          end
        end
        S_QRY_SUB: begin
          key   <= alu_sum;
          state <= S_QRY_FIN;
        end
        S_QRY_FIN: begin
          res_pend <= stq_pkg::mk_res(stq_pkg::STATUS_OK, 1'b0, 8'd0,
                                      1'b1, alu_sum[31:0], 1'b1);
          state    <= S_EMIT;
        end

        // Hand a word to the output register once it frees
        S_EMIT: begin
          if (out_free) begin
            state <= ret_idle ? S_IDLE : S_TICK_RD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Queue never holds more than its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // Tick never takes more than the per-tick budget
  a_tick_budget: assert property (@(posedge clk) disable iff (rst)
    n_taken <= stq_pkg::RES_CNT_W'(stq_pkg::MAX_RES))
    else $error("tick took too many entries");

  // Insert scan stays inside the occupied region
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_RD || state == S_INS_CMP) |-> (idx <= count && count != CNT_W'(DEPTH)))
    else $error("insert scan out of range");

  // An expiry word carries no other answer
  a_expiry_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.expired_valid) |->
      (res.status == stq_pkg::STATUS_OK && !res.next_valid))
    else $error("expiry word mixed with other fields");

  // A taken head entry shrinks the queue by exactly one
  a_drop_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK_CMP && alu_carry) |=> (count == $past(count) - CNT_W'(1)))
    else $error("head drop miscounted");
`endif

endmodule

@@ rtl/core/stq_alu.sv @@
// Shared add/subtract unit with carry out, used for all time arithmetic and compares.
module stq_alu #(
  parameter int unsigned TW = 48
) (
  input  stq_pkg::alu_op_t op,
  input  logic [TW-1:0]    a,
  input  logic [TW-1:0]    b,
  output logic [TW-1:0]    sum,
  output logic             carry
);

  logic [TW-1:0] b_eff;

  // Subtract as a + ~b + 1; carry set means a >= b
  assign b_eff = (op == stq_pkg::ALU_SUB) ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} +
                        {{TW{1'b0}}, (op == stq_pkg::ALU_SUB)};

endmodule

@@ rtl/core/stq_mem.sv @@
// Entry store: expiry time and id per slot, one address per cycle, registered read.
module stq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned TW    = 48,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [TW-1:0] wr_time,
  input  logic [7:0]    wr_id,
  input  logic          re,
  output logic [TW-1:0] rd_time,
  output logic [7:0]    rd_id
);

  logic [TW-1:0] time_mem [DEPTH];
  logic [7:0]    id_mem   [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[addr] <= wr_time;
      id_mem[addr]   <= wr_id;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_time <= time_mem[addr];
      rd_id   <= id_mem[addr];
    end
  end

endmodule
